// ===== hdl/ysm_pkg.sv =====
// Shared types and constants for the Yasmarang ranged generator.
package ysm_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned DatWidth  = 8;
  localparam int unsigned IdxWidth  = 2;
  localparam int unsigned CntWidth  = 6;

  // Configuration register indexes
  localparam logic [IdxWidth-1:0] RegSeedPad = 2'd0;
  localparam logic [IdxWidth-1:0] RegSeedN   = 2'd1;
  localparam logic [IdxWidth-1:0] RegSeedD   = 2'd2;

  // Request codes
  localparam logic OpRaw    = 1'b0;
  localparam logic OpRanged = 1'b1;

  // Generator shift amounts and masks
  localparam int unsigned PadRotL  = 3;
  localparam int unsigned PadRotR  = 29;
  localparam int unsigned DMixL    = 31;
  localparam int unsigned DMixR    = 1;
  localparam int unsigned DatShift = 8;
  localparam int unsigned OutDL    = 5;
  localparam int unsigned OutPR    = 18;
  localparam int unsigned OutDatL  = 1;
  localparam logic [WordWidth-1:0] NOrMask = 32'd2;
  localparam logic [DatWidth-1:0]  DatXor  = 8'd1;

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic seed;
    logic mul;
    logic step;
  } gen_ctl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/ysm_gen.sv =====
// Yasmarang generator state with a registered d*n product and a registered step.
module ysm_gen import ysm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  gen_ctl_t ctl,
  input  word_t    seed_pad,
  input  word_t    seed_n,
  input  word_t    seed_d,
  output word_t    word
);

  logic                seeded;
  word_t               pad;
  word_t               n;
  word_t               d;
  logic [DatWidth-1:0] dat;
  word_t               prod;

  word_t               p0;
  word_t               p;
  word_t               d_next;
  logic [DatWidth-1:0] dat_next;
  word_t               word_next;

  always_comb begin
    p0        = pad + word_t'(dat) + prod;
    p         = (p0 << PadRotL) + (p0 >> PadRotR);
    d_next    = d ^ ((p << DMixL) + (p >> DMixR));
    dat_next  = dat ^ p[DatWidth-1:0] ^ d_next[DatShift +: DatWidth] ^ DatXor;
    word_next = p ^ (d_next << OutDL) ^ (p >> OutPR) ^ (word_t'(dat_next) << OutDatL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
      pad    <= '0;
      n      <= '0;
      d      <= '0;
      dat    <= '0;
    end else if (ctl.seed && !seeded) begin
      seeded <= 1'b1;
      pad    <= seed_pad;
      n      <= seed_n;
      d      <= seed_d;
      dat    <= '0;
    end else if (ctl.step) begin
      pad <= p;
      n   <= p | NOrMask;
      d   <= d_next;
      dat <= dat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= d * n;
    end
    if (ctl.step) begin
      word <= word_next;
    end
  end

endmodule

// ===== hdl/ysm_div.sv =====
// Restoring radix-2 remainder unit, one quotient bit per cycle.
module ysm_div import ysm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  word_t     dividend,
  input  word_t     divisor,
  output div_stat_t stat,
  output word_t     rem
);

  word_t                 dvd;
  word_t                 dvsr;
  logic [CntWidth-1:0]   cnt;
  logic                  done;
  logic [WordWidth:0]    shifted;
  logic [WordWidth:0]    diff;

  always_comb begin
    shifted = {rem, dvd[WordWidth-1]};
    diff    = shifted - {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CntWidth'(WordWidth);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CntWidth'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvd  <= dividend;
      dvsr <= divisor;
    end else if (cnt != '0) begin
      // keep the trial difference when it does not go negative
      rem <= diff[WordWidth] ? shifted[WordWidth-1:0] : diff[WordWidth-1:0];
      dvd <= dvd << 1;
    end
  end

  assign stat.done = done;

endmodule

// ===== hdl/yasmarang_prng_ranged_unit.sv =====
// Top level of the Yasmarang generator with range reduction.
//
//  channel   direction  handshake             payload
//  request   in         in_valid / in_stall   opcode, low_bound, high_bound
//  result    out        out_valid / out_stall value
//  config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A raw request passes from accept to result register through these steps: accept,
// product d*n, generator step, load result. A ranged request adds the
// remainder unit: a start, one step per bit of the word and a wait to see done.
// A ranged request with equal bounds goes from accept straight to load result.
// Reset clears the seeds, the generator and the sequencer; the first
// advancing request loads the generator from the seed registers.
// A stalled result beat holds in the output register; the sequencer holds
// its final state until the register is free.
module yasmarang_prng_ranged_unit import ysm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [31:0]         low_bound,
  input  logic [31:0]         high_bound,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         value,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IdxWidth-1:0] cfg_index,
  input  logic [31:0]         cfg_data
);

  state_t    state;
  state_t    state_next;
  gen_ctl_t  gen_ctl;
  div_stat_t div_stat;
  logic      div_start;
  logic      accept;
  logic      out_free;
  logic      bounds_equal;

  word_t     seed_pad;
  word_t     seed_n;
  word_t     seed_d;

  logic      op_q;
  logic      zero_q;
  word_t     lo_q;
  word_t     span_q;

  word_t     gen_word;
  word_t     div_rem;
  word_t     result;

  // Configuration is always taken; the seeds only matter at first use.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_pad <= '0;
      seed_n   <= '0;
      seed_d   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegSeedPad: seed_pad <= cfg_data;
        RegSeedN:   seed_n   <= cfg_data;
        RegSeedD:   seed_d   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Take a request only when the sequencer is parked.
  assign in_stall     = (state != ST_IDLE);
  assign accept       = in_valid && !in_stall;
  assign bounds_equal = (low_bound == high_bound);
  assign out_free     = !out_valid || !out_stall;

  // Latch the request; the span wraps when the bounds are reversed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      zero_q <= (opcode == OpRanged) && bounds_equal;
      lo_q   <= low_bound;
      span_q <= high_bound - low_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    gen_ctl    = '0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((opcode == OpRanged) && bounds_equal) begin
            state_next = ST_FIN;
          end else begin
            // seed on the first advancing request after reset
            gen_ctl.seed = 1'b1;
            state_next   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        gen_ctl.mul = 1'b1;
        state_next  = ST_STEP;
      end
      ST_STEP: begin
        gen_ctl.step = 1'b1;
        state_next   = (op_q == OpRanged) ? ST_DIV_GO : ST_FIN;
      end
      ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  ysm_gen u_gen (
    .clk      (clk),
    .rst      (rst),
    .ctl      (gen_ctl),
    .seed_pad (seed_pad),
    .seed_n   (seed_n),
    .seed_d   (seed_d),
    .word     (gen_word)
  );

  ysm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (gen_word),
    .divisor  (span_q),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  // Pick the finished value: zero for equal bounds, else raw or reduced word.
  always_comb begin
    if (zero_q) begin
      result = '0;
    end else if (op_q == OpRanged) begin
      result = div_rem + lo_q;
    end else begin
      result = gen_word;
    end
  end

  // Output register: load on finish, drop the beat once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      value <= result;
    end
  end

endmodule
